FILE: rtl/ssnd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnd_pkg: shared types and constants for the seven segment number display
// Holds the segment code tables, register indexes, tdata layout and the
// command and status groups that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package ssnd_pkg;

    // input tdata layout: position, value, width, zero pad to whole bytes
    localparam int POS_W      = 3;
    localparam int VAL_W      = 32;
    localparam int WID_W      = 4;
    localparam int IN_TDATA_W = 40;
    localparam int POS_LSB    = 0;
    localparam int VAL_LSB    = POS_LSB + POS_W;
    localparam int WID_LSB    = VAL_LSB + VAL_W;

    localparam int SEG_W  = 8;
    localparam int CNT_W  = 5;   // digit counts up to sixteen
    localparam int SYM_W  = 4;
    localparam int TSEL_W = 2;
    localparam int DCNT_W = 4;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_TABLE_SELECT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIGIT_COUNT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LATCH_USED   = 2'd2;

    // table select codes
    localparam logic [TSEL_W-1:0] TSEL_STANDARD = 2'd0;
    localparam logic [TSEL_W-1:0] TSEL_MODULE   = 2'd1;
    localparam logic [TSEL_W-1:0] TSEL_TOWER    = 2'd2;
    localparam logic [TSEL_W-1:0] TSEL_SPARE    = 2'd3;

    localparam logic [SYM_W-1:0]  SYM_ZERO  = 4'd0;
    localparam logic [SYM_W-1:0]  SYM_BLANK = 4'd10;
    localparam logic [SEG_W-1:0]  SEG_BLANK = 8'hFF;
    localparam logic [SEG_W-1:0]  SEG_ZERO_STANDARD = 8'hC0;
    localparam logic [DCNT_W-1:0] DCNT_RESET = 4'd8;

    // reciprocal of ten, exact for 32-bit dividends with a 35-bit shift
    localparam logic [VAL_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               QUOT_W = 2 * VAL_W - RECIP_SHIFT;

    localparam logic [SEG_W-1:0] CODE_STANDARD [0:10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90, 8'hFF
    };
    // the three-digit module and the tower layout share one wiring
    localparam logic [SEG_W-1:0] CODE_MODULE [0:10] = '{
        8'h82, 8'hAF, 8'h91, 8'h85, 8'hAC, 8'hC4, 8'hC0, 8'h8F, 8'h80, 8'h84, 8'hFF
    };
    localparam logic [SEG_W-1:0] CODE_TOWER [0:10] = '{
        8'h82, 8'hAF, 8'h91, 8'h85, 8'hAC, 8'hC4, 8'hC0, 8'h8F, 8'h80, 8'h84, 8'hFF
    };

    typedef struct packed {
        logic capture;  // take the input transaction
        logic mul;      // register the reciprocal product
        logic dig;      // write one digit, step the value
        logic emit;     // load one store byte into the output register
    } cmd_t;

    typedef struct packed {
        logic refresh;    // input op is refresh
        logic set_go;     // set item fits and has digits to write
        logic count_zero; // no digits in use
        logic dig_done;   // current digit is the last one
        logic k_last;     // current byte is the last of the refresh
        logic out_free;   // output register can take a byte
    } sts_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [TSEL_W-1:0] tsel,
                                                  input logic [SYM_W-1:0]  sym);
        logic [SEG_W-1:0] code;
        code = SEG_BLANK;
        if (sym <= SYM_BLANK) begin
            unique case (tsel)
                TSEL_STANDARD: code = CODE_STANDARD[sym];
                TSEL_MODULE:   code = CODE_MODULE[sym];
                TSEL_TOWER:    code = CODE_TOWER[sym];
                TSEL_SPARE:    code = CODE_STANDARD[sym];
            endcase
        end
        return code;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/seven_segment_number_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_display: decimal driver for common-anode digits
// Keeps one segment byte per digit, writes decimal numbers into it and
// shifts the used bytes out to the display chain on a refresh.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// s_axis    in         tvalid/tready         tdata: position, value, width
//                                            tuser: op (0 set, 1 refresh)
// m_axis    out        tvalid/tready         tdata: seg_byte
//                                            tlast: last, tuser: latch_active
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_wdata
//
// in a set transaction each decimal digit goes through the reciprocal
// multiplier, then splits off the remainder and writes the store; a set
// that does not fit is taken and writes nothing
// a refresh sends one byte per digit in use and holds while m_axis
// stalls; the next transaction is taken once the last byte sits in
// the output register
// synchronous active-low reset; store comes up as the standard zero code
// config is always ready; the user is to write it only while the block is idle, which the block leaves unchecked
//
module seven_segment_number_display #(
    parameter int MAX_DIGITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [2:0] position, [34:3] value,
                                            // [38:35] width, [39] zero
    input  wire logic        s_axis_tuser,  // [0] op
    // result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] seg_byte
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,  // [0] latch_active
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata
);
    import ssnd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // register writes never wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ssnd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssnd_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

    // the controller issues at most one datapath step per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.mul, cmd.dig, cmd.emit}))
        else $error("more than one datapath command at once");

    // a refresh with digits in use holds off further input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser && !sts.count_zero)
        |=> !s_axis_tready)
        else $error("input taken during a refresh");

    // a byte is only loaded when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_axis_tvalid)
        else $error("emitted byte not presented");

    // after the last digit the block is ready again
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.dig && sts.dig_done) |=> s_axis_tready)
        else $error("not ready after last digit");

endmodule
`default_nettype wire

FILE: rtl/ssnd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnd_ctrl: sequencing state machine
// Accepts one item at a time and steps the datapath through the digit
// loop of a set item or the byte loop of a refresh.
// ----------------------------------------------------------------------------
module ssnd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  ssnd_pkg::sts_t     sts,
    output ssnd_pkg::cmd_t     cmd
);
    import ssnd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    if (sts.refresh) begin
                        if (!sts.count_zero) begin
                            state_next = S_SEND;
                        end
                    end else if (sts.set_go) begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIG;
            end
            S_DIG: begin
                cmd.dig    = 1'b1;
                state_next = sts.dig_done ? S_IDLE : S_MUL;
            end
            S_SEND: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.k_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ssnd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnd_datapath: digit store, divide-by-ten unit and output register
// Holds the configuration registers and the segment byte store, peels off
// decimal digits in multiply and digit steps and feeds refresh bytes out.
// ----------------------------------------------------------------------------
module ssnd_datapath #(
    parameter int MAX_DIGITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [ssnd_pkg::IN_TDATA_W-1:0]     in_tdata,
    input  wire logic                                in_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [ssnd_pkg::CIDX_W-1:0]         cfg_index,
    input  wire logic [ssnd_pkg::CDAT_W-1:0]         cfg_wdata,
    input  wire logic                                out_ready,
    input  ssnd_pkg::cmd_t                           cmd,
    output ssnd_pkg::sts_t                           sts,
    output logic                                     out_valid,
    output logic [ssnd_pkg::SEG_W-1:0]               out_data,
    output logic                                     out_last,
    output logic                                     out_user
);
    import ssnd_pkg::*;

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    logic [TSEL_W-1:0] tsel_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              latch_reg;
    logic [SEG_W-1:0]  store_reg  [MAX_DIGITS];
    logic [SEG_W-1:0]  store_next [MAX_DIGITS];

    logic [VAL_W-1:0]  val_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [IW-1:0]     idx_reg;
    logic [WID_W-1:0]  left_reg;
    logic              first_reg;
    logic [IW-1:0]     k_reg;

    logic              out_valid_reg;
    logic [SEG_W-1:0]  out_data_reg;
    logic              out_last_reg;
    logic              out_user_reg;

    logic [POS_W-1:0]   in_pos;
    logic [VAL_W-1:0]   in_val;
    logic [WID_W-1:0]   in_wid;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   span;
    logic [2*VAL_W-1:0] product;
    logic [VAL_W:0]     quot_x10;
    logic [VAL_W:0]     remainder;
    logic [SYM_W-1:0]   sym;

    assign in_pos = in_tdata[POS_LSB +: POS_W];
    assign in_val = in_tdata[VAL_LSB +: VAL_W];
    assign in_wid = in_tdata[WID_LSB +: WID_W];

    // digit count saturates at the store depth
    assign count = (CNT_W'(dcnt_reg) > MAX_CNT) ? MAX_CNT : CNT_W'(dcnt_reg);
    assign span  = CNT_W'(in_pos) + CNT_W'(in_wid);

    // divide by ten: product registered, remainder from quotient times ten
    assign product   = (2*VAL_W)'(val_reg) * (2*VAL_W)'(RECIP_TEN);
    assign quot_x10  = (VAL_W+1)'({quot_reg, 3'b000}) + (VAL_W+1)'({quot_reg, 1'b0});
    assign remainder = (VAL_W+1)'(val_reg) - quot_x10;

    always_comb begin
        if (val_reg == '0) begin
            sym = first_reg ? SYM_ZERO : SYM_BLANK;
        end else begin
            sym = remainder[SYM_W-1:0];
        end
    end

    always_comb begin
        store_next = store_reg;
        priority if (cfg_we && cfg_index == REG_TABLE_SELECT) begin
            for (int e = 0; e < MAX_DIGITS; e++) begin
                store_next[e] = seg_code(cfg_wdata[TSEL_W-1:0], SYM_ZERO);
            end
        end else if (cfg_we && cfg_index == REG_DIGIT_COUNT) begin
            for (int e = 0; e < MAX_DIGITS; e++) begin
                store_next[e] = seg_code(tsel_reg, SYM_ZERO);
            end
        end else if (cmd.dig) begin
            store_next[idx_reg] = seg_code(tsel_reg, sym);
        end else begin
            // store holds its contents
            store_next = store_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsel_reg  <= TSEL_STANDARD;
            dcnt_reg  <= DCNT_RESET;
            latch_reg <= 1'b0;
            for (int e = 0; e < MAX_DIGITS; e++) begin
                store_reg[e] <= SEG_ZERO_STANDARD;
            end
        end else begin
            store_reg <= store_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TABLE_SELECT: tsel_reg  <= cfg_wdata[TSEL_W-1:0];
                    REG_DIGIT_COUNT:  dcnt_reg  <= cfg_wdata[DCNT_W-1:0];
                    REG_LATCH_USED:   latch_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload of the item in progress
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            val_reg   <= in_val;
            idx_reg   <= IW'(count - span);
            left_reg  <= in_wid;
            first_reg <= 1'b1;
            k_reg     <= '0;
        end
        if (cmd.mul) begin
            quot_reg <= product[2*VAL_W-1:RECIP_SHIFT];
        end
        if (cmd.dig) begin
            val_reg   <= VAL_W'(quot_reg);
            idx_reg   <= idx_reg + IW'(1);
            left_reg  <= left_reg - WID_W'(1);
            first_reg <= 1'b0;
        end
        if (cmd.emit) begin
            k_reg        <= k_reg + IW'(1);
            out_data_reg <= store_reg[k_reg];
            out_last_reg <= sts.k_last;
            out_user_reg <= latch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.refresh    = in_tuser;
    assign sts.set_go     = (span <= count) && (in_wid != '0);
    assign sts.count_zero = (count == '0);
    assign sts.dig_done   = (left_reg == WID_W'(1));
    assign sts.k_last     = (CNT_W'(k_reg) + CNT_W'(1)) == count;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the seven segment number display
// Sends set-number and refresh transactions under several register settings,
// keeps its own copy of the digit store and checks every refresh byte, its
// last flag and its latch level against the bytes that copy predicts.
// ----------------------------------------------------------------------------
module tb;
    import ssnd_pkg::*;

    localparam int STORE_DEPTH    = 8;     // matches the default MAX_DIGITS
    localparam int SETTLE_CYCLES  = 40;    // long enough for the longest set, eight digits wide
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
    localparam int ITEMS_PER_PHASE = 27;
    localparam int RANDOM_PHASES  = 7;

    // register index that the block has to ignore
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {
        OP_SET_NUMBER = 1'b0,
        OP_REFRESH    = 1'b1
    } disp_op_t;

    typedef struct {
        disp_op_t    op;
        logic [2:0]  position;
        logic [31:0] value;
        logic [3:0]  width;
    } disp_item_t;

    typedef struct {
        logic [7:0] seg_byte;
        logic       last;
        logic       latch;
    } seg_out_t;

    // segment codes per decimal digit, entry ten is the blank code
    localparam logic [7:0] STD_SEGMENTS [0:10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90, 8'hFF
    };
    // the module and the tower layout are wired alike
    localparam logic [7:0] ALT_SEGMENTS [0:10] = '{
        8'h82, 8'hAF, 8'h91, 8'h85, 8'hAC, 8'hC4, 8'hC0, 8'h8F, 8'h80, 8'h84, 8'hFF
    };

    // ------------------------------------------------------------------------
    // clock, reset and block ports, every input known from time zero
    // ------------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [2:0] position, [34:3] value, [38:35] width
    logic        s_axis_tuser  = 1'b0; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] seg_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // [0] latch_active
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [3:0]  cfg_wdata     = '0;

    always #4 aclk = ~aclk;

    seven_segment_number_display u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // shadow of the display state: digit store and the three registers
    // ------------------------------------------------------------------------
    logic [7:0]        shadow_store [STORE_DEPTH];
    logic [TSEL_W-1:0] shadow_tsel;
    logic [DCNT_W-1:0] shadow_dcnt;
    logic              shadow_latch;

    disp_item_t pending_items[$];   // transactions still to be sent
    seg_out_t   refresh_bytes_q[$]; // bytes the display chain should see next

    int mismatch_count = 0;

    // idling switches, flipped per phase so that some stretches run flat out
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    function automatic logic [7:0] segment_code(input logic [TSEL_W-1:0] tsel, input int sym);
        if (tsel == TSEL_MODULE || tsel == TSEL_TOWER)
            return ALT_SEGMENTS[sym];
        // standard table, the spare select code falls back to it as well
        return STD_SEGMENTS[sym];
    endfunction

    function automatic int unsigned digits_in_use();
        return (shadow_dcnt > STORE_DEPTH) ? STORE_DEPTH : shadow_dcnt;
    endfunction

    function automatic void refill_shadow();
        foreach (shadow_store[k])
            shadow_store[k] = segment_code(shadow_tsel, 0);
    endfunction

    // apply one accepted transaction to the shadow store; a refresh queues
    // the bytes the block has to shift out
    task automatic model_display_item(input disp_item_t it);
        int unsigned cnt;
        int unsigned disp_pos;
        int          sym;
        logic [31:0] rest;
        seg_out_t    ob;
        cnt = digits_in_use();
        if (it.op == OP_REFRESH) begin
            for (int unsigned k = 0; k < cnt; k++) begin
                ob.seg_byte = shadow_store[k];
                ob.last     = (k + 1 == cnt);
                ob.latch    = shadow_latch;
                refresh_bytes_q.push_back(ob);
            end
        end else if (int'(it.position) + int'(it.width) <= int'(cnt)) begin
            rest = it.value;
            for (int unsigned i = 1; i <= it.width; i++) begin
                disp_pos = it.position + it.width - i;
                // leading zeros go blank, but a zero value still shows one 0
                if (rest == 0)
                    sym = (i == 1) ? 0 : 10;
                else
                    sym = rest % 10;
                // display positions count from the right, the store from the left
                shadow_store[cnt - 1 - disp_pos] = segment_code(shadow_tsel, sym);
                rest = rest / 10;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: feeds input transactions from pending_items with random gaps
    // ------------------------------------------------------------------------
    disp_item_t  send_item;
    int unsigned send_gap;
    int unsigned send_draw;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            // transaction taken at this edge, predict before anything else moves
            model_display_item(send_item);
            send_draw = send_idle_en ? $urandom_range(0, 6) : 0;
            if (send_draw == 0 && pending_items.size() > 0) begin
                // back to back: valid stays high with the next payload
                send_item     = pending_items.pop_front();
                s_axis_tdata  <= {1'b0, send_item.width, send_item.value, send_item.position};
                s_axis_tuser  <= send_item.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_draw;
            end
        end else if (!s_axis_tvalid) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                send_item     = pending_items.pop_front();
                s_axis_tdata  <= {1'b0, send_item.width, send_item.value, send_item.position};
                s_axis_tuser  <= send_item.op;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure on the result side and the byte check
    // ------------------------------------------------------------------------
    int unsigned recv_gap;
    int unsigned recv_draw;
    seg_out_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (refresh_bytes_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: seg_byte %02h last %0b latch %0b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = refresh_bytes_q.pop_front();
                if (m_axis_tdata !== want.seg_byte || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.latch) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: seg_byte exp %02h got %02h, ",
                                  "last exp %0b got %0b, latch exp %0b got %0b"},
                                 want.seg_byte, m_axis_tdata, want.last, m_axis_tlast,
                                 want.latch, m_axis_tuser);
                end
            end
            recv_draw = recv_idle_en ? $urandom_range(0, 6) : 0;
            if (recv_draw != 0) begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_draw;
            end
        end else if (!m_axis_tready) begin
            if (recv_gap != 0)
                recv_gap <= recv_gap - 1;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any transaction on any channel restarts the count
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // register write, shadow updated at the edge the block takes it
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TABLE_SELECT: begin
                shadow_tsel = data[TSEL_W-1:0];
                refill_shadow();
            end
            REG_DIGIT_COUNT: begin
                shadow_dcnt = data;
                refill_shadow();
            end
            REG_LATCH_USED: shadow_latch = data[0];
            default: ;   // unused index, nothing changes
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(input disp_op_t op, input logic [2:0] pos,
                             input logic [31:0] val, input logic [3:0] wid);
        disp_item_t it;
        it.op       = op;
        it.position = pos;
        it.value    = val;
        it.width    = wid;
        pending_items.push_back(it);
    endtask

    // sender holds off until every expected byte is back, then lets a set
    // that leaves no result finish before the registers change
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_axis_tvalid || refresh_bytes_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed sets that fit the display, some refreshes, a little noise
    function automatic disp_item_t random_item();
        disp_item_t  it;
        int unsigned cnt;
        int unsigned roll;
        cnt         = digits_in_use();
        roll        = $urandom_range(0, 99);
        it.op       = OP_SET_NUMBER;
        it.position = $urandom_range(0, 7);
        it.width    = $urandom_range(0, 15);
        case ($urandom_range(0, 5))
            0:       it.value = 32'd0;
            1:       it.value = 32'hFFFF_FFFF;
            default: it.value = $urandom >> $urandom_range(0, 31);
        endcase
        if (roll < 22) begin
            it.op = OP_REFRESH;   // other fields left random on purpose
        end else if (roll < 88 && cnt > 0) begin
            it.width    = $urandom_range(0, cnt);
            it.position = $urandom_range(0, cnt - it.width);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        shadow_tsel  = TSEL_STANDARD;
        shadow_dcnt  = DCNT_RESET;
        shadow_latch = 1'b0;
        refill_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, zero value, full width, too wide, width zero
        @(negedge aclk);
        push_item(OP_REFRESH,    3'd0, 32'd0,         4'd0);
        push_item(OP_SET_NUMBER, 3'd0, 32'd0,         4'd1);
        push_item(OP_SET_NUMBER, 3'd0, 32'hFFFF_FFFF, 4'd8);
        push_item(OP_REFRESH,    3'd0, 32'd0,         4'd0);
        push_item(OP_SET_NUMBER, 3'd0, 32'hFFFF_FFFF, 4'd10);
        push_item(OP_SET_NUMBER, 3'd7, 32'd9,         4'd1);
        push_item(OP_SET_NUMBER, 3'd3, 32'd0,         4'd4);
        push_item(OP_SET_NUMBER, 3'd5, 32'd1234,      4'd0);
        push_item(OP_SET_NUMBER, 3'd7, 32'd55,        4'd2);
        push_item(OP_SET_NUMBER, 3'd7, 32'h1234_5678, 4'd15);
        push_item(OP_REFRESH,    3'd0, 32'd0,         4'd0);
        push_item(OP_SET_NUMBER, 3'd2, 32'd123456,    4'd6);
        push_item(OP_REFRESH,    3'd7, 32'hFFFF_FFFF, 4'd15);
        wait_idle();

        // module table, three digits, latch line on; blanks past the value
        write_reg(REG_TABLE_SELECT, {2'b00, TSEL_MODULE});
        write_reg(REG_DIGIT_COUNT,  4'd3);
        write_reg(REG_LATCH_USED,   4'd1);
        @(negedge aclk);
        push_item(OP_SET_NUMBER, 3'd0, 32'hFFFF_FFFF, 4'd3);
        push_item(OP_REFRESH,    3'd0, 32'd0,         4'd0);
        push_item(OP_SET_NUMBER, 3'd0, 32'd10,        4'd3);
        push_item(OP_REFRESH,    3'd0, 32'd0,         4'd0);
        wait_idle();

        // tower table with spare upper data bits, count above the store saturates
        write_reg(REG_TABLE_SELECT, {2'b11, TSEL_TOWER});
        write_reg(REG_DIGIT_COUNT,  4'd15);
        @(negedge aclk);
        push_item(OP_SET_NUMBER, 3'd0, 32'd4000000000, 4'd8);
        push_item(OP_REFRESH,    3'd0, 32'd0,          4'd0);
        wait_idle();

        // spare table code, no digits in use, ignored register index
        write_reg(REG_TABLE_SELECT, {2'b10, TSEL_SPARE});
        write_reg(REG_DIGIT_COUNT,  4'd0);
        write_reg(REG_UNUSED,       4'hF);
        write_reg(REG_LATCH_USED,   4'hE);
        @(negedge aclk);
        push_item(OP_REFRESH,    3'd0, 32'd0, 4'd0);
        push_item(OP_SET_NUMBER, 3'd0, 32'd5, 4'd0);
        push_item(OP_SET_NUMBER, 3'd0, 32'd5, 4'd1);
        wait_idle();

        // single digit display
        write_reg(REG_DIGIT_COUNT, 4'd1);
        @(negedge aclk);
        push_item(OP_SET_NUMBER, 3'd0, 32'd7, 4'd1);
        push_item(OP_REFRESH,    3'd0, 32'd0, 4'd0);
        wait_idle();

        // random phases, first three pin the extremes of the digit count
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            send_idle_en = (ph % 3 != 1);
            recv_idle_en = (ph % 3 != 2);
            write_reg(REG_TABLE_SELECT,
                      {2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))});
            case (ph)
                0:       write_reg(REG_DIGIT_COUNT, 4'd8);
                1:       write_reg(REG_DIGIT_COUNT, 4'd1);
                2:       write_reg(REG_DIGIT_COUNT, 4'd15);
                default: write_reg(REG_DIGIT_COUNT, 4'($urandom_range(1, 8)));
            endcase
            write_reg(REG_LATCH_USED, 4'($urandom_range(0, 15)));
            @(negedge aclk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_items.push_back(random_item());
            wait_idle();
        end

        if (mismatch_count == 0 && refresh_bytes_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
